@@ rtl/core/lpht_pkg.sv @@
// shared constants and codes for the linear probing hash table
package lpht_pkg;

    localparam int OPCODE_BITS    = 3;
    localparam int STATUS_BITS    = 2;
    localparam int COUNT_BITS     = 6;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int MISS_BITS      = 32;

    localparam logic [OPCODE_BITS-1:0] OP_GET        = 3'd0;
    localparam logic [OPCODE_BITS-1:0] OP_SET        = 3'd1;
    localparam logic [OPCODE_BITS-1:0] OP_CLEAR      = 3'd2;
    localparam logic [OPCODE_BITS-1:0] OP_ITER_FIRST = 3'd3;
    localparam logic [OPCODE_BITS-1:0] OP_ITER_NEXT  = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_END  = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOAD_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MISS_VALUE = 2'd1;

    localparam logic [COUNT_BITS-1:0] LOAD_LIMIT_RESET = 6'd32;
    localparam logic [MISS_BITS-1:0]  MISS_VALUE_RESET = 32'd0;

endpackage

@@ rtl/core/lpht_channels.sv @@
// valid/ready channel interfaces for requests, responses and configuration
interface lpht_req_if #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
);
    import lpht_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OPCODE_BITS-1:0] opcode;
    logic [KEY_BITS-1:0]    key;
    logic [VALUE_BITS-1:0]  value;

    modport source (output valid, output opcode, output key, output value, input ready);
    modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface lpht_rsp_if #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
);
    import lpht_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [VALUE_BITS-1:0]  value_out;
    logic [KEY_BITS-1:0]    key_out;
    logic [COUNT_BITS-1:0]  entry_count;

    modport source (output valid, output status, output value_out, output key_out,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input value_out, input key_out,
                    input entry_count, output ready);
endinterface

interface lpht_cfg_if;
    import lpht_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/linear_probe_hash_table_unit.sv @@
// key/value store with open addressing and linear probing over one slot memory
//
// channels: req carries opcode, key and value; rsp returns status, value_out,
// key_out and entry_count, one response per request; cfg writes load_limit
// (index 0) and miss_value (index 1) and is always ready.
// slots live in one synchronous memory of SLOTS entries {valid, key, value},
// read one entry per cycle through a registered read port.
// get and set read the home slot, then probe the following slots in turn,
// wrapping at the end, until an empty slot, a matching key or SLOTS probed
// slots; iter_next skips empty slots from the walk position; iter_first and
// unknown opcodes answer directly; clear makes one memory write per slot.
// when SLOTS is not a power of two the home slot is reduced one key bit per
// cycle before probing starts.
// one request is in flight at a time, so a new request is taken only once the
// last one has gone into the response register; the next request is taken
// while the response register still waits for the receiver.
// reset: load_limit 32, miss_value 0, empty table; a clearing pass over all
// SLOTS slots runs after reset before the first request is taken.
// a stalled receiver holds the response register; a finished request then
// waits in place, with its memory write held back until the response moves.
module linear_probe_hash_table_unit #(
    parameter int SLOTS      = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    lpht_cfg_if.sink    cfg,
    lpht_req_if.sink    req,
    lpht_rsp_if.source  rsp
);
    import lpht_pkg::*;

    localparam int  AW   = $clog2(SLOTS);
    localparam int  WW   = $clog2(SLOTS + 1);
    localparam int  HW   = $clog2(KEY_BITS);
    localparam int  KW   = (KEY_BITS > AW) ? KEY_BITS : AW;
    localparam bit  POW2 = (SLOTS & (SLOTS - 1)) == 0;

    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
    localparam logic [WW-1:0] WALK_END  = WW'(SLOTS);
    localparam logic [AW:0]   SLOTS_EXT = (AW + 1)'(SLOTS);

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    typedef enum logic [5:0] {
        S_SWEEP  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_HASH   = 6'b000100,
        S_PROBE  = 6'b001000,
        S_WALK   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    entry_t mem [SLOTS];
    entry_t mem_rdata;
    entry_t mem_wdata;
    logic   mem_re;
    logic   mem_we;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] mem_waddr;

    state_t                 state_reg, state_next;
    logic [OPCODE_BITS-1:0] op_reg, op_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [AW-1:0]          probes_reg, probes_next;
    logic [HW-1:0]          hcnt_reg, hcnt_next;
    logic [AW-1:0]          rem_reg, rem_next;
    logic [WW-1:0]          walk_reg, walk_next;
    logic [AW-1:0]          sweep_reg, sweep_next;
    logic                   sweep_rsp_reg, sweep_rsp_next;
    logic [STATUS_BITS-1:0] fin_status_reg, fin_status_next;
    logic [COUNT_BITS-1:0]  occ_reg, occ_next;
    logic [COUNT_BITS-1:0]  limit_reg;
    logic [MISS_BITS-1:0]   miss_reg;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic [STATUS_BITS-1:0] rsp_status_reg;
    logic [VALUE_BITS-1:0]  rsp_value_reg;
    logic [KEY_BITS-1:0]    rsp_key_reg;
    logic [COUNT_BITS-1:0]  rsp_count_reg;

    logic                   emit;
    logic [STATUS_BITS-1:0] e_status;
    logic [VALUE_BITS-1:0]  e_value;
    logic [KEY_BITS-1:0]    e_key;
    logic [COUNT_BITS-1:0]  e_count;

    logic [KW-1:0]  key_wide;
    logic [AW:0]    hash_t;
    logic [AW-1:0]  hash_rem;
    logic [AW-1:0]  pos_inc;
    logic [WW-1:0]  walk_inc;
    logic           hit;
    logic           out_free;

    // slot memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= mem[mem_raddr];
        end
    end

    assign key_wide = KW'(req.key);
    assign hash_t   = {rem_reg, key_reg[hcnt_reg]};
    assign hash_rem = (hash_t >= SLOTS_EXT) ? AW'(hash_t - SLOTS_EXT) : AW'(hash_t);
    assign pos_inc  = (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
    assign walk_inc = walk_reg + 1'b1;
    assign hit      = mem_rdata.valid && (mem_rdata.key == key_reg);
    assign out_free = !rsp_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        probes_next     = probes_reg;
        hcnt_next       = hcnt_reg;
        rem_next        = rem_reg;
        walk_next       = walk_reg;
        sweep_next      = sweep_reg;
        sweep_rsp_next  = sweep_rsp_reg;
        fin_status_next = fin_status_reg;
        occ_next        = occ_reg;
        mem_re          = 1'b0;
        mem_raddr       = pos_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = '0;
        emit            = 1'b0;
        e_status        = ST_OK;
        e_value         = '0;
        e_key           = '0;
        e_count         = occ_reg;

        unique case (state_reg)
            S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                if (sweep_reg == LAST_SLOT)
                begin
                    sweep_next      = '0;
                    fin_status_next = ST_OK;
                    state_next      = sweep_rsp_reg ? S_FINISH : S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next  = req.opcode;
                    key_next = req.key;
                    val_next = req.value;
                    case (req.opcode) inside
                        OP_GET, OP_SET:
                        begin
                            probes_next = '0;
                            if (POW2)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = key_wide[AW-1:0];
                                pos_next   = key_wide[AW-1:0];
                                state_next = S_PROBE;
                            end
                            else
                            begin
                                rem_next   = '0;
                                hcnt_next  = HW'(KEY_BITS - 1);
                                state_next = S_HASH;
                            end
                        end
                        OP_CLEAR:
                        begin
                            occ_next       = '0;
                            sweep_next     = '0;
                            sweep_rsp_next = 1'b1;
                            state_next     = S_SWEEP;
                        end
                        OP_ITER_FIRST:
                        begin
                            walk_next       = '0;
                            fin_status_next = ST_OK;
                            state_next      = S_FINISH;
                        end
                        OP_ITER_NEXT:
                        begin
                            if (walk_reg == WALK_END)
                            begin
                                fin_status_next = ST_END;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = walk_reg[AW-1:0];
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            fin_status_next = ST_OK;
                            state_next      = S_FINISH;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                rem_next = hash_rem;
                if (hcnt_reg == '0)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = hash_rem;
                    pos_next   = hash_rem;
                    state_next = S_PROBE;
                end
                else
                begin
                    hcnt_next = hcnt_reg - 1'b1;
                end
            end
            S_PROBE:
            begin
                if (!mem_rdata.valid || hit || probes_reg == LAST_SLOT)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (op_reg == OP_GET)
                        begin
                            if (hit)
                            begin
                                e_value = mem_rdata.value;
                            end
                            else
                            begin
                                e_status = ST_MISS;
                                e_value  = VALUE_BITS'(miss_reg);
                            end
                        end
                        else if (hit)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = '{valid: 1'b1, key: key_reg, value: val_reg};
                        end
                        else if (mem_rdata.valid || occ_reg >= limit_reg)
                        begin
                            e_status = ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = '{valid: 1'b1, key: key_reg, value: val_reg};
                            occ_next  = occ_reg + 1'b1;
                            e_count   = occ_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    pos_next    = pos_inc;
                    probes_next = probes_reg + 1'b1;
                    mem_re      = 1'b1;
                    mem_raddr   = pos_inc;
                end
            end
            S_WALK:
            begin
                if (mem_rdata.valid)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_key      = mem_rdata.key;
                        walk_next  = walk_inc;
                        state_next = S_IDLE;
                    end
                end
                else if (walk_reg == WW'(SLOTS - 1))
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_status   = ST_END;
                        walk_next  = walk_inc;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    walk_next = walk_inc;
                    mem_re    = 1'b1;
                    mem_raddr = walk_inc[AW-1:0];
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_status   = fin_status_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_valid_next = rsp_valid_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            sweep_reg      <= '0;
            sweep_rsp_reg  <= 1'b0;
            occ_reg        <= '0;
            walk_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            sweep_rsp_reg  <= sweep_rsp_next;
            occ_reg        <= occ_next;
            walk_reg       <= walk_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        probes_reg     <= probes_next;
        hcnt_reg       <= hcnt_next;
        rem_reg        <= rem_next;
        fin_status_reg <= fin_status_next;
        if (emit)
        begin
            rsp_status_reg <= e_status;
            rsp_value_reg  <= e_value;
            rsp_key_reg    <= e_key;
            rsp_count_reg  <= e_count;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LOAD_LIMIT_RESET;
            miss_reg  <= MISS_VALUE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_LOAD_LIMIT: limit_reg <= cfg.data[COUNT_BITS-1:0];
                CFG_MISS_VALUE: miss_reg  <= cfg.data[MISS_BITS-1:0];
                default:        ;
            endcase
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.value_out   = rsp_value_reg;
    assign rsp.key_out     = rsp_key_reg;
    assign rsp.entry_count = rsp_count_reg;

endmodule

@@ dv/linear_probe_hash_table_unit_tb.sv @@
// testbench for the linear probing hash table unit: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module linear_probe_hash_table_unit_tb;
    import lpht_pkg::*;

    localparam int SLOTS          = 64;
    localparam int KEY_BITS       = 32;
    localparam int VALUE_BITS     = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * SLOTS + 8;
    localparam int CFG_SETTLE     = 4;

    localparam logic [OPCODE_BITS-1:0] OP_SPARE_FIRST = OP_ITER_NEXT + 1'b1;
    localparam logic [OPCODE_BITS-1:0] OP_SPARE_LAST  = '1;

    typedef struct {
        logic [OPCODE_BITS-1:0] opcode;
        logic [KEY_BITS-1:0]    key;
        logic [VALUE_BITS-1:0]  value;
        int                     gap;
    } request_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [VALUE_BITS-1:0]  value_out;
        logic [KEY_BITS-1:0]    key_out;
        logic [COUNT_BITS-1:0]  entry_count;
    } response_t;

    logic clk = 1'b0;
    logic rst_n;

    lpht_req_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) req_ch ();
    lpht_rsp_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) rsp_ch ();
    lpht_cfg_if cfg_ch ();

    linear_probe_hash_table_unit #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    // predicted table contents
    logic                  table_used  [SLOTS];
    logic [KEY_BITS-1:0]   table_key   [SLOTS];
    logic [VALUE_BITS-1:0] table_value [SLOTS];
    int                    entry_total;
    int                    walk_index;
    logic [COUNT_BITS-1:0] limit_reg;
    logic [MISS_BITS-1:0]  miss_reg;

    request_t  pending_requests[$];
    response_t expected_responses[$];
    request_t  next_req;
    int        pushed_count;
    int        accepted_count;
    int        fail_count;
    int        send_hold;
    int        take_hold;
    int        take_stall;
    int        stall_cycles;
    bit        quiet_sender;
    bit        quiet_receiver;

    function automatic void probe_table(input logic [KEY_BITS-1:0] k, output bit hit,
                                        output int slot, output bit has_empty);
        int pos;
        int n;
        pos       = k % SLOTS;
        hit       = 1'b0;
        has_empty = 1'b0;
        slot      = 0;
        for (n = 0; n < SLOTS; n++)
        begin
            if (!table_used[pos])
            begin
                slot      = pos;
                has_empty = 1'b1;
                return;
            end
            if (table_key[pos] == k)
            begin
                slot = pos;
                hit  = 1'b1;
                return;
            end
            pos = (pos + 1) % SLOTS;
        end
    endfunction

    function automatic void predict_response(input logic [OPCODE_BITS-1:0] op,
                                             input logic [KEY_BITS-1:0] k,
                                             input logic [VALUE_BITS-1:0] v);
        response_t r;
        bit        hit;
        bit        has_empty;
        int        slot;
        int        p;
        r        = '0;
        r.status = ST_OK;
        probe_table(k, hit, slot, has_empty);
        case (op)
            OP_GET:
            begin
                if (hit)
                    r.value_out = table_value[slot];
                else
                begin
                    r.status    = ST_MISS;
                    r.value_out = miss_reg;
                end
            end
            OP_SET:
            begin
                if (hit)
                    table_value[slot] = v;
                else if (!has_empty || entry_total >= limit_reg)
                    r.status = ST_FULL;
                else
                begin
                    table_used[slot]  = 1'b1;
                    table_key[slot]   = k;
                    table_value[slot] = v;
                    entry_total++;
                end
            end
            OP_CLEAR:
            begin
                foreach (table_used[i])
                    table_used[i] = 1'b0;
                entry_total = 0;
            end
            OP_ITER_FIRST:
                walk_index = 0;
            OP_ITER_NEXT:
            begin
                r.status = ST_END;
                while (walk_index < SLOTS)
                begin
                    p = walk_index;
                    walk_index++;
                    if (table_used[p])
                    begin
                        r.key_out = table_key[p];
                        r.status  = ST_OK;
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = entry_total[COUNT_BITS-1:0];
        expected_responses.push_back(r);
    endfunction

    function automatic void queue_request(input logic [OPCODE_BITS-1:0] op,
                                          input logic [KEY_BITS-1:0] k,
                                          input logic [VALUE_BITS-1:0] v);
        request_t t;
        if ($urandom_range(0, 19) == 0)
            quiet_sender = !quiet_sender;
        t.opcode = op;
        t.key    = k;
        t.value  = v;
        t.gap    = quiet_sender ? 0 : $urandom_range(0, 4);
        pending_requests.push_back(t);
        pushed_count++;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch on %s: expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_response();
        response_t want;
        if (expected_responses.size() == 0)
        begin
            $display("%0t unexpected response: expected none actual status %0d key %h",
                     $time, rsp_ch.status, rsp_ch.key_out);
            fail_count++;
        end
        else
        begin
            want = expected_responses.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_ch.status));
            compare_field("value_out", want.value_out, rsp_ch.value_out);
            compare_field("key_out", want.key_out, rsp_ch.key_out);
            compare_field("entry_count", 32'(want.entry_count), 32'(rsp_ch.entry_count));
        end
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_LOAD_LIMIT)
            limit_reg = data[COUNT_BITS-1:0];
        else if (idx == CFG_MISS_VALUE)
            miss_reg = data[MISS_BITS-1:0];
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (accepted_count != pushed_count || expected_responses.size() != 0);
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic fill_random_phase(input int count);
        logic [KEY_BITS-1:0] pool [16];
        int                  base;
        int                  n;
        int                  pick;
        int                  walk_len;
        base = $urandom_range(0, SLOTS - 1);
        foreach (pool[i])
            pool[i] = ($urandom() & ~32'h3F) | ((base + $urandom_range(0, 5)) % SLOTS);
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                queue_request(OP_SET, pool[$urandom_range(0, 15)], $urandom());
            else if (pick < 75)
                queue_request(OP_GET, pool[$urandom_range(0, 15)], $urandom());
            else if (pick < 82)
                queue_request($urandom_range(0, 1) ? OP_SET : OP_GET, $urandom(), $urandom());
            else if (pick < 90)
            begin
                walk_len = $urandom_range(1, 8);
                queue_request(OP_ITER_FIRST, $urandom(), $urandom());
                repeat (walk_len) queue_request(OP_ITER_NEXT, $urandom(), $urandom());
                n += walk_len;
            end
            else if (pick < 93)
                queue_request(OP_CLEAR, $urandom(), $urandom());
            else if (pick < 96)
            begin
                queue_request(OPCODE_BITS'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                              $urandom(), $urandom());
                n--;
            end
            else
                queue_request(OP_ITER_NEXT, $urandom(), $urandom());
            n++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid  <= 1'b0;
            req_ch.opcode <= OP_GET;
            req_ch.key    <= '0;
            req_ch.value  <= '0;
            send_hold     <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_response(req_ch.opcode, req_ch.key, req_ch.value);
                accepted_count++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_hold > 0)
                begin
                    send_hold    <= send_hold - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    next_req = pending_requests.pop_front();
                    req_ch.valid  <= 1'b1;
                    req_ch.opcode <= next_req.opcode;
                    req_ch.key    <= next_req.key;
                    req_ch.value  <= next_req.value;
                    send_hold     <= next_req.gap;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            take_hold    <= 0;
        end
        else if (rsp_ch.valid && rsp_ch.ready)
        begin
            check_response();
            if ($urandom_range(0, 19) == 0)
                quiet_receiver = !quiet_receiver;
            take_stall = quiet_receiver ? 0 : $urandom_range(0, 4);
            take_hold    <= take_stall;
            rsp_ch.ready <= (take_stall == 0);
        end
        else if (take_hold > 1)
        begin
            take_hold    <= take_hold - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            take_hold    <= 0;
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic [KEY_BITS-1:0] k_a;
        logic [KEY_BITS-1:0] k_b;
        int                  op;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.opcode  = OP_GET;
        req_ch.key     = '0;
        req_ch.value   = '0;
        rsp_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_LOAD_LIMIT;
        cfg_ch.data    = '0;
        stall_cycles   = 0;
        pushed_count   = 0;
        accepted_count = 0;
        fail_count     = 0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        foreach (table_used[i])
        begin
            table_used[i]  = 1'b0;
            table_key[i]   = '0;
            table_value[i] = '0;
        end
        entry_total = 0;
        walk_index  = 0;
        limit_reg   = LOAD_LIMIT_RESET;
        miss_reg    = MISS_VALUE_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, collisions, wrap-around, update, walk, spare opcodes, clear
        queue_request(OP_GET, 32'h0, 32'hFFFF_FFFF);
        queue_request(OP_ITER_NEXT, 32'h0, 32'h0);
        queue_request(OP_SET, 32'h0, 32'hFFFF_FFFF);
        queue_request(OP_SET, 32'hFFFF_FFFF, 32'h0);
        queue_request(OP_SET, 32'h40, 32'h1234_5678);
        queue_request(OP_SET, 32'h80, 32'h8765_4321);
        queue_request(OP_SET, 32'h7F, 32'h0F0F_0F0F);
        queue_request(OP_GET, 32'h7F, 32'h0);
        queue_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
        queue_request(OP_SET, 32'h0, 32'hA5A5_A5A5);
        queue_request(OP_GET, 32'hC0, 32'h0);
        queue_request(OP_ITER_FIRST, 32'h0, 32'h0);
        repeat (6) queue_request(OP_ITER_NEXT, 32'h0, 32'h0);
        queue_request(OP_ITER_NEXT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (op = int'(OP_SPARE_FIRST); op <= int'(OP_SPARE_LAST); op++)
            queue_request(OPCODE_BITS'(op), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(OP_CLEAR, 32'h0, 32'h0);
        queue_request(OP_GET, 32'h0, 32'h0);
        queue_request(OP_ITER_NEXT, 32'h0, 32'h0);
        wait_quiet();

        // smallest limits, update at the limit, all-ones miss value
        write_register(CFG_MISS_VALUE, 32'hFFFF_FFFF);
        write_register(CFG_LOAD_LIMIT, 32'd1);
        k_a = $urandom();
        k_b = $urandom() ^ 32'h8000_0000;
        queue_request(OP_CLEAR, 32'h0, 32'h0);
        queue_request(OP_SET, k_a, 32'h1111_1111);
        queue_request(OP_SET, k_b, 32'h2222_2222);
        queue_request(OP_SET, k_a, 32'h3333_3333);
        queue_request(OP_GET, k_b, 32'h0);
        queue_request(OP_GET, k_a, 32'h0);
        wait_quiet();
        write_register(CFG_LOAD_LIMIT, 32'd0);
        queue_request(OP_CLEAR, 32'h0, 32'h0);
        queue_request(OP_SET, k_b, 32'h4444_4444);
        queue_request(OP_GET, k_b, 32'h0);
        wait_quiet();

        // nearly full table with long probe chains
        write_register(CFG_LOAD_LIMIT, 32'd63);
        queue_request(OP_CLEAR, 32'h0, 32'h0);
        for (op = 0; op < 63; op++)
            queue_request(OP_SET, ($urandom() & 32'hFFFF_F000) | (op << 6) | $urandom_range(0, 3),
                          $urandom());
        queue_request(OP_SET, 32'hFFFF_F03F, 32'h5555_5555);
        queue_request(OP_GET, 32'hFFFF_FFC0, 32'h0);
        queue_request(OP_GET, 32'h0000_0FC1, 32'h0);
        queue_request(OP_ITER_FIRST, 32'h0, 32'h0);
        repeat (SLOTS + 1) queue_request(OP_ITER_NEXT, 32'h0, 32'h0);
        wait_quiet();

        for (op = 0; op < 5; op++)
        begin
            case (op)
                0: write_register(CFG_LOAD_LIMIT, 32'd63);
                1: write_register(CFG_LOAD_LIMIT, $urandom_range(2, 62));
                2: write_register(CFG_LOAD_LIMIT, 32'd4);
                3: write_register(CFG_LOAD_LIMIT, $urandom_range(1, 63));
                default: write_register(CFG_LOAD_LIMIT, CFG_DATA_BITS'(LOAD_LIMIT_RESET));
            endcase
            case (op)
                1: write_register(CFG_MISS_VALUE, 32'h0);
                2: write_register(CFG_MISS_VALUE, 32'hFFFF_FFFF);
                default: write_register(CFG_MISS_VALUE, $urandom());
            endcase
            fill_random_phase(70);
            wait_quiet();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ linear_probe_hash_table_unit.f @@
rtl/core/lpht_pkg.sv
rtl/core/lpht_channels.sv
rtl/core/linear_probe_hash_table_unit.sv
dv/linear_probe_hash_table_unit_tb.sv
